// File: rtl/core/wdq_pkg.sv
package wdq_pkg;

   typedef enum logic [1:0] {
      FMT_SINGLE = 2'd0,
      FMT_HALF   = 2'd1,
      FMT_Q8     = 2'd2,
      FMT_NONE   = 2'd3
   } fmt_type;

   typedef enum logic {
      CSR_FORMAT = 1'b0,
      CSR_COUNT  = 1'b1
   } csr_idx_type;

   localparam logic [5:0]  Q8_BLOCK_BYTES = 6'd34;
   localparam logic [31:0] CANON_NAN      = 32'h7FC0_0000;

   // Count leading zeros of a 10-bit mantissa; returns 10 when zero.
   function automatic logic [3:0] lz10(input logic [9:0] m);
      logic [3:0] n;
      n = 4'd10;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) n = 4'(9 - i);
      end
      return n;
   endfunction

   // Exact half to single; NaN becomes canonical with its sign.
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic        s;
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [3:0]  z;
      logic [10:0] sh;
      logic [31:0] r;
      s   = h[15];
      ex  = h[14:10];
      man = h[9:0];
      z   = lz10(man);
      sh  = {1'b0, man} << (z + 4'd1);
      if (ex == 5'd0) begin
         if (man == 10'd0) r = {s, 31'd0};
         else r = {s, 8'(8'd112 - 8'(z)), sh[9:0], 13'd0};
      end else if (ex == 5'h1F) begin
         r = (man == 10'd0) ? {s, 31'h7F80_0000} : ({s, 31'd0} | CANON_NAN);
      end else begin
         r = {s, 8'(8'(ex) + 8'd112), man, 13'd0};
      end
      return r;
   endfunction

endpackage

// File: rtl/core/weight_dequantizer_to_float32.sv
// The word of a completing byte is loaded into the result register as that byte is accepted.
// Throughput: one byte per cycle while the output is not stalled; a half scale times
// byte multiply and a normalize per byte sit between the input byte and the result register.
// Reset: synchronous; format and element count clear to zero, stream ended.
module weight_dequantizer_to_float32 import wdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value_bits,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [1:0]  fmt_ff;
   logic [31:0] count_ff;
   logic [23:0] gather_ff, gather_in;
   logic [5:0]  pos_ff, pos_in;
   logic [15:0] scale_ff, scale_in;
   logic [31:0] left_ff, left_in;
   logic        ovalid_ff, ovalid_in;
   logic [31:0] oval_ff, oval_in;
   logic        olast_ff, olast_in;

   logic        acc, emit, restart;
   logic [31:0] val;
   logic [31:0] sbits;
   logic [7:0]  qmag;
   logic        psign;
   logic [18:0] prod;
   logic [4:0]  lz;
   logic [18:0] nprod;
   logic [8:0]  pexp;
   logic [31:0] qres;

   function automatic logic csr_index_type_is_fmt(input logic [0:0] idx);
      return csr_idx_type'(idx) == CSR_FORMAT;
   endfunction

   assign csr_ready = 1'b1;
   assign restart   = csr_valid;
   assign req_stall = ovalid_ff & rsp_stall;
   assign acc       = req_valid & ~req_stall;

   assign rsp_valid      = ovalid_ff;
   assign rsp_value_bits = oval_ff;
   assign rsp_last       = olast_ff;

   always_comb begin
      sbits = half_to_single(scale_ff);
      qmag  = req_data_byte[7] ? 8'(-req_data_byte) : req_data_byte;
      psign = scale_ff[15] ^ req_data_byte[7];
      prod  = 19'({1'b1, sbits[22:13]}) * 19'(qmag);
      lz    = 5'd0;
      for (int i = 0; i < 19; i++) begin
         if (prod[i]) lz = 5'(18 - i);
      end
      nprod = prod << lz;
      pexp  = 9'(sbits[30:23]) + 9'd8 - 9'(lz);
      if (sbits[30:23] == 8'hFF) begin
         qres = (sbits[22:0] != 23'd0 || qmag == 8'd0) ?
                ({psign, 31'd0} | CANON_NAN) : {psign, 31'h7F80_0000};
      end else if (sbits[30:23] == 8'd0 || qmag == 8'd0) begin
         qres = {psign, 31'd0};
      end else if (pexp > 9'd254) begin
         qres = {psign, 31'h7F80_0000};
      end else begin
         qres = {psign, pexp[7:0], nprod[17:0], 5'd0};
      end
   end

   always_comb begin
      gather_in = gather_ff;
      pos_in    = pos_ff;
      scale_in  = scale_ff;
      left_in   = left_ff;
      emit      = 1'b0;
      val       = 32'd0;
      if (acc && left_ff != 32'd0) begin
         case (fmt_type'(fmt_ff))
            FMT_SINGLE: begin
               if (pos_ff >= 6'd3) begin
                  val = {req_data_byte, gather_ff};
                  gather_in = 24'd0;
                  pos_in = 6'd0;
                  emit = 1'b1;
               end else begin
                  gather_in = gather_ff | (24'(req_data_byte) << {pos_ff[1:0], 3'd0});
                  pos_in = pos_ff + 6'd1;
               end
            end
            FMT_HALF: begin
               if (pos_ff >= 6'd1) begin
                  val = half_to_single({req_data_byte, gather_ff[7:0]});
                  gather_in = 24'd0;
                  pos_in = 6'd0;
                  emit = 1'b1;
               end else begin
                  gather_in = 24'(req_data_byte);
                  pos_in = 6'd1;
               end
            end
            FMT_Q8: begin
               if (pos_ff == 6'd0) begin
                  scale_in = 16'(req_data_byte);
                  pos_in = 6'd1;
               end else if (pos_ff == 6'd1) begin
                  scale_in = {req_data_byte, scale_ff[7:0]};
                  pos_in = 6'd2;
               end else begin
                  val = qres;
                  emit = 1'b1;
                  pos_in = (pos_ff + 6'd1 >= Q8_BLOCK_BYTES) ? 6'd0 : pos_ff + 6'd1;
               end
            end
            default: ;
         endcase
      end
      if (emit) begin
         left_in = left_ff - 32'd1;
         if (left_in == 32'd0) begin
            gather_in = 24'd0;
            pos_in = 6'd0;
         end
      end
      ovalid_in = emit | (ovalid_ff & rsp_stall);
      oval_in   = emit ? val : oval_ff;
      olast_in  = emit ? (left_in == 32'd0) : olast_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= 2'd0;
         count_ff  <= 32'd0;
         gather_ff <= 24'd0;
         pos_ff    <= 6'd0;
         scale_ff  <= 16'd0;
         left_ff   <= 32'd0;
         ovalid_ff <= 1'b0;
      end else if (restart) begin
         if (csr_index_type_is_fmt(csr_index)) fmt_ff <= csr_data[1:0];
         else count_ff <= csr_data;
         gather_ff <= 24'd0;
         pos_ff    <= 6'd0;
         scale_ff  <= 16'd0;
         left_ff   <= csr_index_type_is_fmt(csr_index) ? count_ff : csr_data;
         ovalid_ff <= ovalid_in;
      end else begin
         gather_ff <= gather_in;
         pos_ff    <= pos_in;
         scale_ff  <= scale_in;
         left_ff   <= left_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      oval_ff  <= oval_in;
      olast_ff <= olast_in;
   end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import wdq_pkg::*;

   typedef struct packed {
      logic [31:0] bits;
      logic        last;
   } element_type;

   localparam int LIMIT_CYCLES = 600000;
   localparam int SETTLE_CYCLES = 4;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_value_bits;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [31:0] csr_data;

   element_type pending_elements[$];
   int          errors;
   int          cycles;
   int          sender_idle_pct;
   int          receiver_idle_pct;
   int          hold_off;

   fmt_type     pred_format;
   logic [31:0] pred_count;
   logic [31:0] pred_left;
   logic [23:0] pred_gather;
   logic [5:0]  pred_pos;
   logic [15:0] pred_scale;

   weight_dequantizer_to_float32 dut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [31:0] widen_half(input logic [15:0] h);
      logic [10:0] m;
      logic [7:0]  e;
      m = {1'b0, h[9:0]};
      e = 8'd0;
      if (h[14:10] == 5'd0) begin
         if (m == 11'd0) return {h[15], 31'd0};
         while (!m[10]) begin
            m = m << 1;
            e = e + 8'd1;
         end
         return {h[15], 8'(8'd113 - e), m[9:0], 13'd0};
      end
      if (h[14:10] == 5'h1F)
         return (m == 11'd0) ? {h[15], 31'h7F80_0000} : ({h[15], 31'd0} | CANON_NAN);
      return {h[15], 8'(8'(h[14:10]) + 8'd112), h[9:0], 13'd0};
   endfunction

   function automatic logic [31:0] scale_byte(input logic [7:0] b, input logic [15:0] h);
      logic        psign;
      logic [8:0]  mag;
      logic [10:0] sig;
      logic [19:0] prod;
      int          k;
      int          expo;
      logic [42:0] aligned;
      psign = h[15] ^ b[7];
      mag = b[7] ? 9'(9'd256 - 9'(b)) : 9'(b);
      if (h[14:10] == 5'h1F) begin
         if (h[9:0] != 10'd0 || mag == 9'd0) return {psign, 31'd0} | CANON_NAN;
         return {psign, 31'h7F80_0000};
      end
      sig = (h[14:10] == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
      if (sig == 11'd0 || mag == 9'd0) return {psign, 31'd0};
      prod = 20'(sig) * 20'(mag);
      k = 0;
      for (int i = 0; i < 20; i++) begin
         if (prod[i]) k = i;
      end
      expo = k + ((h[14:10] == 5'd0) ? 1 : int'(h[14:10])) - 25 + 127;
      aligned = 43'(prod) << (23 - k);
      return {psign, 8'(expo), aligned[22:0]};
   endfunction

   function automatic void restart_stream();
      pred_gather = 24'd0;
      pred_pos = 6'd0;
      pred_scale = 16'd0;
      pred_left = pred_count;
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      logic [31:0] val;
      logic        emit;
      emit = 1'b0;
      val = 32'd0;
      if (pred_left == 32'd0 || pred_format == FMT_NONE) return;
      case (pred_format)
         FMT_SINGLE: begin
            if (pred_pos >= 6'd3) begin
               val = {b, pred_gather};
               pred_gather = 24'd0;
               pred_pos = 6'd0;
               emit = 1'b1;
            end else begin
               pred_gather[8 * pred_pos +: 8] = b;
               pred_pos = pred_pos + 6'd1;
            end
         end
         FMT_HALF: begin
            if (pred_pos >= 6'd1) begin
               val = widen_half({b, pred_gather[7:0]});
               pred_gather = 24'd0;
               pred_pos = 6'd0;
               emit = 1'b1;
            end else begin
               pred_gather = {16'd0, b};
               pred_pos = 6'd1;
            end
         end
         default: begin
            if (pred_pos == 6'd0) begin
               pred_scale = {8'd0, b};
               pred_pos = 6'd1;
            end else if (pred_pos == 6'd1) begin
               pred_scale[15:8] = b;
               pred_pos = 6'd2;
            end else begin
               val = scale_byte(b, pred_scale);
               emit = 1'b1;
               pred_pos = pred_pos + 6'd1;
               if (pred_pos >= Q8_BLOCK_BYTES) pred_pos = 6'd0;
            end
         end
      endcase
      if (!emit) return;
      pred_left = pred_left - 32'd1;
      pending_elements.push_back('{bits: val, last: pred_left == 32'd0});
      if (pred_left == 32'd0) begin
         pred_gather = 24'd0;
         pred_pos = 6'd0;
      end
   endfunction

   always @(posedge clock) begin
      element_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_elements.size() == 0) begin
            errors++;
            $display("%0t: unexpected word value %h last %b", $realtime, rsp_value_bits,
                     rsp_last);
         end else begin
            want = pending_elements.pop_front();
            if (rsp_value_bits !== want.bits) begin
               errors++;
               $display("%0t: value_bits expected %h actual %h", $realtime, want.bits,
                        rsp_value_bits);
            end
            if (rsp_last !== want.last) begin
               errors++;
               $display("%0t: last expected %b actual %b", $realtime, want.last, rsp_last);
            end
         end
      end
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      predict_byte(b);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FORMAT) pred_format = fmt_type'(value[1:0]);
      else pred_count = value;
      restart_stream();
   endtask

   task automatic send_word(input logic [31:0] w, input int nbytes);
      for (int i = 0; i < nbytes; i++) send_byte(w[8 * i +: 8]);
   endtask

   task automatic test_single_passthrough();
      write_csr(CSR_FORMAT, FMT_SINGLE);
      write_csr(CSR_COUNT, 32'd5);
      send_word(32'h0000_0000, 4);
      send_word(32'hFFFF_FFFF, 4);
      send_word(32'h7F80_0001, 4);
      send_word(32'h8000_0000, 4);
      send_word(32'h3F80_0000, 4);
      send_word(32'hDEAD_BEEF, 4);
   endtask

   task automatic test_half_conversion();
      logic [15:0] halves[12] = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h0400,
                                  16'h7BFF, 16'h7C00, 16'hFC00, 16'h7C01, 16'hFE00,
                                  16'h3C00, 16'h8200};
      write_csr(CSR_FORMAT, FMT_HALF);
      write_csr(CSR_COUNT, 32'd12);
      foreach (halves[i]) send_word(32'(halves[i]), 2);
      send_word(32'h1234, 2);
   endtask

   task automatic test_q8_blocks();
      logic [15:0] scales[6] = '{16'h3C00, 16'h7E01, 16'hFC00, 16'h8000, 16'h0001, 16'h7BFF};
      logic [7:0]  probes[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
      write_csr(CSR_FORMAT, FMT_Q8);
      foreach (scales[s]) begin
         write_csr(CSR_COUNT, 32'd4);
         send_word(32'(scales[s]), 2);
         foreach (probes[i]) send_byte(probes[i]);
         send_byte(8'h01);
      end
      write_csr(CSR_COUNT, 32'd33);
      for (int i = 0; i < 70; i++) send_byte(8'($urandom));
   endtask

   task automatic test_ignored_and_restart();
      write_csr(CSR_FORMAT, FMT_NONE);
      write_csr(CSR_COUNT, 32'd8);
      for (int i = 0; i < 6; i++) send_byte(8'($urandom));
      write_csr(CSR_COUNT, 32'd0);
      write_csr(CSR_FORMAT, FMT_SINGLE);
      for (int i = 0; i < 6; i++) send_byte(8'($urandom));
      write_csr(CSR_COUNT, 32'hFFFF_FFFF);
      send_word(32'h00AB_CDEF, 3);
      write_csr(CSR_FORMAT, FMT_SINGLE);
      send_word(32'h4049_0FDB, 4);
      write_csr(CSR_FORMAT, FMT_Q8);
      send_word(32'h00_3C00, 3);
      write_csr(CSR_COUNT, 32'd2);
      send_word(32'hFE02_4000, 4);
   endtask

   task automatic test_backpressure();
      write_csr(CSR_FORMAT, FMT_HALF);
      write_csr(CSR_COUNT, 32'd60);
      hold_off = 300;
      for (int i = 0; i < 120; i++) send_byte(8'($urandom));
      drain();
   endtask

   task automatic test_random_streams(input int budget);
      int          sent;
      int          nbytes;
      logic [31:0] count;
      fmt_type     fmt;
      sent = 0;
      while (sent < budget) begin
         fmt = fmt_type'(($urandom_range(19) == 0) ? 3 : $urandom_range(2));
         case ($urandom_range(19))
            0: count = 32'd0;
            1: count = 32'hFFFF_FFFF;
            2: count = 32'($urandom);
            default: count = 32'($urandom_range(1, 40));
         endcase
         if (count > 32'd64) nbytes = $urandom_range(20, 120);
         else if (fmt == FMT_SINGLE) nbytes = 4 * count;
         else if (fmt == FMT_HALF) nbytes = 2 * count;
         else nbytes = 34 * (count / 32) + ((count % 32 != 0) ? 2 + count % 32 : 0);
         nbytes = nbytes + $urandom_range(0, 6) - 3;
         if (nbytes < 1) nbytes = 1;
         write_csr(CSR_FORMAT, fmt);
         write_csr(CSR_COUNT, count);
         for (int i = 0; i < nbytes; i++) send_byte(8'($urandom));
         sent += nbytes;
      end
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      hold_off = 0;
      sender_idle_pct = 27;
      receiver_idle_pct = 50;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'd0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_FORMAT;
      csr_data = 32'd0;
      pred_format = FMT_SINGLE;
      pred_count = 32'd0;
      restart_stream();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_passthrough();
      test_half_conversion();
      test_q8_blocks();
      test_ignored_and_restart();
      test_backpressure();

      test_random_streams(530);
      sender_idle_pct = 50;
      receiver_idle_pct = 27;
      test_random_streams(530);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random_streams(530);
      drain();

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: weight_dequantizer_to_float32.f
rtl/core/wdq_pkg.sv
rtl/core/weight_dequantizer_to_float32.sv
verif/testbench.sv
